@@ sv/erf_pkg.sv @@
// Shared operation codes and pipeline timing for the Rusanov face flux core.
package erf_pkg;

  // Iteration stages in each floating-point operator (one quotient/root bit each).
  localparam int ERF_ITER = 27;
  // Cycles from operand capture to registered result in each operator.
  localparam int ERF_LAT = ERF_ITER + 2;

  // Canonical quiet NaN.
  localparam logic [31:0] ERF_QNAN = 32'h7FC00000;

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_ADD  = 3'd1,
    OP_DIV  = 3'd2,
    OP_SQRT = 3'd3,
    OP_MAX  = 3'd4
  } erf_op_t;

endpackage

@@ sv/euler_rusanov_face_flux_core.sv @@
// Top level of the 2D Euler Rusanov face flux core.
//
// Input items arrive on the s_ stream: the own state, the neighbor state and
// the normal component in s_tdata, and the direction and face flags in
// s_tuser. Each item yields exactly one result item on the m_ stream with the
// four flux components of the chosen direction in single precision.
// The datapath is fourteen levels of pipelined floating-point operators, each
// level as deep as one operator. One item is accepted every cycle while the
// skid register is empty; the dividers and square roots produce one bit per
// stage and set the depth, not the rate.
// The whole pipeline moves as one: when the receiver stalls, the finished
// result moves into a one-entry skid register and s_tready drops until that
// result is taken, so no item is lost or repeated.
// Reset clears the valid bits and the skid valid flag; s_tready is low during
// reset, no item is in flight afterwards and s_tready is high from the first
// cycle after reset.
module euler_rusanov_face_flux_core import erf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // normal_component, own_density, own_momentum_x, own_momentum_y, own_energy,
  // neighbor_density, neighbor_momentum_x, neighbor_momentum_y, neighbor_energy
  input  logic [287:0] s_tdata,
  // direction, at_face, neighbor_open
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // flux_mass, flux_momentum_x, flux_momentum_y, flux_energy
  output logic [127:0] m_tdata
);

  localparam int NLVL = 14;
  localparam int TOT  = NLVL * ERF_LAT;
  localparam int XW   = 291;

  localparam logic [31:0] F_0P4 = 32'h3ECCCCCD;
  localparam logic [31:0] F_0P2 = 32'h3E4CCCCD;
  localparam logic [31:0] F_1P4 = 32'h3FB33333;
  localparam logic [31:0] F_0P5 = 32'h3F000000;

  function automatic logic [31:0] fneg(input logic [31:0] x);
    return {~x[31], x[30:0]};
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] x);
    return (x[30:0] > 31'h7F800000) ? ERF_QNAN : x;
  endfunction

  logic en;
  logic [TOT-1:0] vld;
  logic [XW-1:0] xt [NLVL+1];
  logic [31:0] ux [NLVL+1][2][4];

  // Stall control: the pipeline advances unless the skid register is full.
  logic         skid_valid;
  logic [127:0] skid_data;
  logic         tail_valid;
  logic [127:0] tail_data;

  assign en       = ~skid_valid;
  assign s_tready = en & ~rst;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], s_tvalid};
    end
  end

  // Input item taps, one per arithmetic level.
  assign xt[0] = {s_tuser, s_tdata};
  for (genvar gj = 0; gj < NLVL; gj++) begin : g_tap
    erf_delay #(.W(XW), .DEPTH(ERF_LAT)) u_tap (
      .clk(clk), .en(en), .d(xt[gj]), .q(xt[gj+1])
    );
  end
  for (genvar gj = 0; gj <= NLVL; gj++) begin : g_ux
    for (genvar gs = 0; gs < 2; gs++) begin : g_s
      for (genvar gd = 0; gd < 4; gd++) begin : g_d
        assign ux[gj][gs][gd] = xt[gj][32 + 128*gs + 32*gd +: 32];
      end
    end
  end

  // Per-state intermediate values.
  logic [31:0] a1 [2], b1 [2], c1 [2], d1 [2], e1 [2], f1 [2], g1 [2], h1 [2];
  logic [31:0] b2 [2], c2 [2], sqd [2], f2 [2], num [2];
  logic [31:0] g1d [2], a1d [2], h1d [2];
  logic [31:0] t1 [2], t2 [2], vq [2], sqdd [2], f2d [2];
  logic [31:0] dd [2], sv [2], t2d [2];
  logic [31:0] pr [2], svd [2];
  logic [31:0] sq [2], e3 [2], kp [2];
  logic [31:0] f3 [2], kk [2], sqd9 [2];
  logic [31:0] ss [2], f3d [2];
  logic [31:0] spd [2];
  logic [31:0] fx [2][4];

  for (genvar gs = 0; gs < 2; gs++) begin : g_st
    // Level 1: products and the velocity along the direction.
    erf_fpop u_a1 (.clk(clk), .en(en), .op(OP_MUL), .a(F_0P4), .b(ux[0][gs][3]), .y(a1[gs]));
    erf_fpop u_b1 (.clk(clk), .en(en), .op(OP_MUL), .a(F_0P2), .b(ux[0][gs][1]), .y(b1[gs]));
    erf_fpop u_c1 (.clk(clk), .en(en), .op(OP_MUL), .a(F_0P2), .b(ux[0][gs][2]), .y(c1[gs]));
    erf_fpop u_d1 (.clk(clk), .en(en), .op(OP_MUL), .a(ux[0][gs][1]), .b(ux[0][gs][1]),
                   .y(d1[gs]));
    erf_fpop u_e1 (.clk(clk), .en(en), .op(OP_MUL), .a(ux[0][gs][2]), .b(ux[0][gs][2]),
                   .y(e1[gs]));
    erf_fpop u_f1 (.clk(clk), .en(en), .op(OP_MUL), .a(ux[0][gs][1]), .b(ux[0][gs][2]),
                   .y(f1[gs]));
    erf_fpop u_g1 (.clk(clk), .en(en), .op(OP_MUL), .a(ux[0][gs][0]), .b(ux[0][gs][0]),
                   .y(g1[gs]));
    erf_fpop u_h1 (.clk(clk), .en(en), .op(OP_DIV),
                   .a(xt[0][288] ? ux[0][gs][2] : ux[0][gs][1]), .b(ux[0][gs][0]),
                   .y(h1[gs]));

    // Level 2: pressure terms, momentum fluxes and the squared speed sum.
    erf_fpop u_b2 (.clk(clk), .en(en), .op(OP_MUL), .a(b1[gs]), .b(ux[1][gs][1]), .y(b2[gs]));
    erf_fpop u_c2 (.clk(clk), .en(en), .op(OP_MUL), .a(c1[gs]), .b(ux[1][gs][2]), .y(c2[gs]));
    erf_fpop u_sqd (.clk(clk), .en(en), .op(OP_DIV), .a(xt[1][288] ? e1[gs] : d1[gs]),
                    .b(ux[1][gs][0]), .y(sqd[gs]));
    erf_fpop u_f2 (.clk(clk), .en(en), .op(OP_DIV), .a(f1[gs]), .b(ux[1][gs][0]), .y(f2[gs]));
    erf_fpop u_num (.clk(clk), .en(en), .op(OP_ADD), .a(d1[gs]), .b(e1[gs]), .y(num[gs]));
    erf_delay #(.W(32), .DEPTH(ERF_LAT)) u_g1d (.clk(clk), .en(en), .d(g1[gs]), .q(g1d[gs]));
    erf_delay #(.W(32), .DEPTH(2*ERF_LAT)) u_a1d (.clk(clk), .en(en), .d(a1[gs]),
                                                  .q(a1d[gs]));
    erf_delay #(.W(32), .DEPTH(5*ERF_LAT)) u_h1d (.clk(clk), .en(en), .d(h1[gs]),
                                                  .q(h1d[gs]));

    // Level 3: divisions by density and the squared velocity magnitude.
    erf_fpop u_t1 (.clk(clk), .en(en), .op(OP_DIV), .a(b2[gs]), .b(ux[2][gs][0]), .y(t1[gs]));
    erf_fpop u_t2 (.clk(clk), .en(en), .op(OP_DIV), .a(c2[gs]), .b(ux[2][gs][0]), .y(t2[gs]));
    erf_fpop u_vq (.clk(clk), .en(en), .op(OP_DIV), .a(num[gs]), .b(g1d[gs]), .y(vq[gs]));
    erf_delay #(.W(32), .DEPTH(3*ERF_LAT)) u_sqdd (.clk(clk), .en(en), .d(sqd[gs]),
                                                   .q(sqdd[gs]));
    erf_delay #(.W(32), .DEPTH(7*ERF_LAT)) u_f2d (.clk(clk), .en(en), .d(f2[gs]),
                                                  .q(f2d[gs]));

    // Level 4 and 5: pressure, and the velocity magnitude at level 4.
    erf_fpop u_dd (.clk(clk), .en(en), .op(OP_ADD), .a(a1d[gs]), .b(fneg(t1[gs])), .y(dd[gs]));
    erf_fpop u_sv (.clk(clk), .en(en), .op(OP_SQRT), .a(vq[gs]), .b(32'd0), .y(sv[gs]));
    erf_delay #(.W(32), .DEPTH(ERF_LAT)) u_t2d (.clk(clk), .en(en), .d(t2[gs]), .q(t2d[gs]));
    erf_fpop u_pr (.clk(clk), .en(en), .op(OP_ADD), .a(dd[gs]), .b(fneg(t2d[gs])), .y(pr[gs]));
    erf_delay #(.W(32), .DEPTH(4*ERF_LAT)) u_svd (.clk(clk), .en(en), .d(sv[gs]),
                                                  .q(svd[gs]));

    // Level 6: pressure enters the fluxes and the sound speed.
    erf_fpop u_sq (.clk(clk), .en(en), .op(OP_ADD), .a(sqdd[gs]), .b(pr[gs]), .y(sq[gs]));
    erf_fpop u_e3 (.clk(clk), .en(en), .op(OP_ADD), .a(ux[5][gs][3]), .b(pr[gs]), .y(e3[gs]));
    erf_fpop u_kp (.clk(clk), .en(en), .op(OP_MUL), .a(F_1P4), .b(pr[gs]), .y(kp[gs]));

    // Level 7 to 9: energy flux, sound speed and wave speed.
    erf_fpop u_f3 (.clk(clk), .en(en), .op(OP_MUL), .a(h1d[gs]), .b(e3[gs]), .y(f3[gs]));
    erf_fpop u_kk (.clk(clk), .en(en), .op(OP_DIV), .a(kp[gs]), .b(ux[6][gs][0]), .y(kk[gs]));
    erf_delay #(.W(32), .DEPTH(3*ERF_LAT)) u_sq9 (.clk(clk), .en(en), .d(sq[gs]),
                                                  .q(sqd9[gs]));
    erf_fpop u_ss (.clk(clk), .en(en), .op(OP_SQRT), .a(kk[gs]), .b(32'd0), .y(ss[gs]));
    erf_delay #(.W(32), .DEPTH(2*ERF_LAT)) u_f3d (.clk(clk), .en(en), .d(f3[gs]),
                                                  .q(f3d[gs]));
    erf_fpop u_spd (.clk(clk), .en(en), .op(OP_ADD), .a(svd[gs]), .b(ss[gs]), .y(spd[gs]));

    // Physical flux of this state, ready at the start of level 10.
    assign fx[gs][0] = xt[9][288] ? ux[9][gs][2] : ux[9][gs][1];
    assign fx[gs][1] = xt[9][288] ? f2d[gs] : sqd9[gs];
    assign fx[gs][2] = xt[9][288] ? sqd9[gs] : f2d[gs];
    assign fx[gs][3] = f3d[gs];
  end

  // Levels 10 to 14: the Rusanov combination of both states.
  logic [31:0] amax, ha, sc;
  logic [31:0] sm [4], df [4], dfd [4], mn [4], mnd [4], jp [4], rs [4], fo [4];

  erf_fpop u_amax (.clk(clk), .en(en), .op(OP_MAX), .a(spd[0]), .b(spd[1]), .y(amax));
  erf_fpop u_ha (.clk(clk), .en(en), .op(OP_MUL), .a(F_0P5), .b(amax), .y(ha));
  erf_fpop u_sc (.clk(clk), .en(en), .op(OP_MUL), .a(ha), .b(xt[11][31:0]), .y(sc));

  for (genvar gd = 0; gd < 4; gd++) begin : g_cmp
    erf_fpop u_sm (.clk(clk), .en(en), .op(OP_ADD), .a(fx[0][gd]), .b(fx[1][gd]), .y(sm[gd]));
    erf_fpop u_df (.clk(clk), .en(en), .op(OP_ADD), .a(ux[9][0][gd]),
                   .b(fneg(ux[9][1][gd])), .y(df[gd]));
    erf_fpop u_mn (.clk(clk), .en(en), .op(OP_MUL), .a(F_0P5), .b(sm[gd]), .y(mn[gd]));
    erf_delay #(.W(32), .DEPTH(2*ERF_LAT)) u_dfd (.clk(clk), .en(en), .d(df[gd]),
                                                  .q(dfd[gd]));
    erf_delay #(.W(32), .DEPTH(2*ERF_LAT)) u_mnd (.clk(clk), .en(en), .d(mn[gd]),
                                                  .q(mnd[gd]));
    erf_fpop u_jp (.clk(clk), .en(en), .op(OP_MUL), .a(sc), .b(dfd[gd]), .y(jp[gd]));
    erf_fpop u_rs (.clk(clk), .en(en), .op(OP_ADD), .a(mnd[gd]), .b(fneg(jp[gd])), .y(rs[gd]));
    erf_delay #(.W(32), .DEPTH(5*ERF_LAT)) u_fo (.clk(clk), .en(en), .d(fx[0][gd]),
                                                 .q(fo[gd]));
    // Open faces take the Rusanov flux, everything else the own physical flux.
    assign tail_data[32*gd +: 32] = canon((xt[NLVL][289] && xt[NLVL][290]) ? rs[gd] : fo[gd]);
  end

  assign tail_valid = vld[TOT-1];

  // Skid register holds a result the receiver has not taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) skid_valid <= 1'b0;
    end else if (tail_valid && !m_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) skid_data <= tail_data;
  end

  assign m_tvalid = skid_valid | tail_valid;
  assign m_tdata  = skid_valid ? skid_data : tail_data;

endmodule

@@ sv/erf_delay.sv @@
// Enable-gated shift line that keeps operands aligned with the arithmetic levels.
module erf_delay import erf_pkg::*; #(
  parameter int W     = 32,
  parameter int DEPTH = ERF_LAT
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  // Shift one place whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

@@ sv/erf_fpop.sv @@
// Pipelined IEEE single-precision operator: multiply, add, divide, square root, max.
module erf_fpop import erf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  erf_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  // Working state of one item inside the operator.
  typedef struct packed {
    erf_op_t             op;
    logic                spec;
    logic [31:0]         sval;
    logic                s;
    logic signed [11:0]  e;
    logic [53:0]         a;
    logic [25:0]         b;
    logic [28:0]         r;
    logic [26:0]         q;
    logic                st;
  } erf_wk_t;

  typedef struct packed {
    logic signed [11:0] e;
    logic [23:0]        m;
  } erf_nrm_t;

  // Normalize a finite nonzero operand to a mantissa with its leading one at bit 23.
  function automatic erf_nrm_t norm24(input logic [7:0] ef, input logic [22:0] fr);
    erf_nrm_t   n;
    logic [4:0] sh;
    sh = 5'd0;
    if (ef != 8'd0) begin
      n.m = {1'b1, fr};
      n.e = $signed({4'd0, ef}) - 12'sd127;
    end else begin
      for (int i = 0; i < 23; i++) begin
        if (fr[i]) sh = 5'(23 - i);
      end
      n.m = {1'b0, fr} << sh;
      n.e = -12'sd126 - $signed({7'd0, sh});
    end
    return n;
  endfunction

  // Ordered less-than; false when either side is NaN, zeros compare equal.
  function automatic logic flt(input logic [31:0] x, input logic [31:0] z);
    logic res;
    if (x[30:0] > 31'h7F800000 || z[30:0] > 31'h7F800000) begin
      res = 1'b0;
    end else if (x[30:0] == 31'd0 && z[30:0] == 31'd0) begin
      res = 1'b0;
    end else if (x[31] != z[31]) begin
      res = x[31];
    end else if (!x[31]) begin
      res = x[30:0] < z[30:0];
    end else begin
      res = x[30:0] > z[30:0];
    end
    return res;
  endfunction

  // Decode operands, settle special values and set up the working fields.
  function automatic erf_wk_t unpack(input erf_op_t o, input logic [31:0] x,
                                     input logic [31:0] z);
    erf_wk_t     w;
    logic        nan_x, nan_z, inf_x, inf_z, zer_x, zer_z, big;
    erf_nrm_t    nx, nz;
    logic [7:0]  ebg, esm;
    logic [31:0] bg, sm;
    logic [24:0] m25;
    logic signed [11:0] ee;
    w = '0;
    w.op = o;
    nan_x = x[30:0] > 31'h7F800000;
    nan_z = z[30:0] > 31'h7F800000;
    inf_x = x[30:0] == 31'h7F800000;
    inf_z = z[30:0] == 31'h7F800000;
    zer_x = x[30:0] == 31'd0;
    zer_z = z[30:0] == 31'd0;
    nx = norm24(x[30:23], x[22:0]);
    nz = norm24(z[30:23], z[22:0]);
    unique case (o)
      OP_MUL: begin
        w.s = x[31] ^ z[31];
        if (nan_x || nan_z || (inf_x && zer_z) || (zer_x && inf_z)) begin
          w.spec = 1'b1; w.sval = ERF_QNAN;
        end else if (inf_x || inf_z) begin
          w.spec = 1'b1; w.sval = {w.s, 31'h7F800000};
        end else if (zer_x || zer_z) begin
          w.spec = 1'b1; w.sval = {w.s, 31'd0};
        end else begin
          w.e = nx.e + nz.e;
          w.b[23:0] = nx.m;
          w.q[23:0] = nz.m;
        end
      end
      OP_ADD: begin
        if (nan_x || nan_z || (inf_x && inf_z && (x[31] != z[31]))) begin
          w.spec = 1'b1; w.sval = ERF_QNAN;
        end else if (inf_x) begin
          w.spec = 1'b1; w.sval = x;
        end else if (inf_z) begin
          w.spec = 1'b1; w.sval = z;
        end else if (zer_x && zer_z) begin
          w.spec = 1'b1; w.sval = {x[31] & z[31], 31'd0};
        end else if (zer_x) begin
          w.spec = 1'b1; w.sval = z;
        end else if (zer_z) begin
          w.spec = 1'b1; w.sval = x;
        end else begin
          big = x[30:0] >= z[30:0];
          bg  = big ? x : z;
          sm  = big ? z : x;
          ebg = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
          esm = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
          w.s = bg[31];
          w.e = $signed({4'd0, ebg}) - 12'sd127;
          w.b[23:0] = {bg[30:23] != 8'd0, bg[22:0]};
          w.q[23:0] = {sm[30:23] != 8'd0, sm[22:0]};
          w.r[7:0] = ebg - esm;
          w.r[8] = x[31] ^ z[31];
        end
      end
      OP_DIV: begin
        w.s = x[31] ^ z[31];
        if (nan_x || nan_z || (inf_x && inf_z) || (zer_x && zer_z)) begin
          w.spec = 1'b1; w.sval = ERF_QNAN;
        end else if (inf_x || zer_z) begin
          w.spec = 1'b1; w.sval = {w.s, 31'h7F800000};
        end else if (inf_z || zer_x) begin
          w.spec = 1'b1; w.sval = {w.s, 31'd0};
        end else begin
          w.b[23:0] = nz.m;
          if (nx.m < nz.m) begin
            w.a[25:0] = {1'b0, nx.m, 1'b0};
            w.e = nx.e - nz.e - 12'sd1;
          end else begin
            w.a[25:0] = {2'b0, nx.m};
            w.e = nx.e - nz.e;
          end
        end
      end
      OP_SQRT: begin
        if (zer_x) begin
          w.spec = 1'b1; w.sval = x;
        end else if (nan_x || x[31]) begin
          w.spec = 1'b1; w.sval = ERF_QNAN;
        end else if (inf_x) begin
          w.spec = 1'b1; w.sval = x;
        end else begin
          if (nx.e[0]) begin
            m25 = {nx.m, 1'b0};
            ee  = nx.e - 12'sd1;
          end else begin
            m25 = {1'b0, nx.m};
            ee  = nx.e;
          end
          w.a = {m25, 29'd0};
          w.e = ee >>> 1;
        end
      end
      OP_MAX: begin
        w.spec = 1'b1;
        w.sval = flt(x, z) ? z : x;
      end
      default: begin
        w.spec = 1'b1; w.sval = ERF_QNAN;
      end
    endcase
    return w;
  endfunction

  // One iteration stage: a quotient or root bit, or a half of multiply or add.
  function automatic erf_wk_t step(input erf_wk_t wi, input int k);
    erf_wk_t     w;
    logic [26:0] big27, sm27, smx, lmask;
    logic [27:0] sum, sh28;
    logic [4:0]  lz;
    logic [25:0] rem;
    logic [30:0] rem2, trial;
    logic [47:0] prod;
    logic        ge;
    w = wi;
    lz = 5'd0;
    if (!w.spec) begin
      unique case (w.op)
        OP_MUL: begin
          if (k == 0) begin
            prod = w.b[23:0] * w.q[23:0];
            w.a  = {6'd0, prod};
          end else if (k == 1) begin
            if (w.a[47]) begin
              w.q  = w.a[47:21];
              w.st = |w.a[20:0];
              w.e  = w.e + 12'sd1;
            end else begin
              w.q  = w.a[46:20];
              w.st = |w.a[19:0];
            end
          end
        end
        OP_ADD: begin
          if (k == 0) begin
            big27 = {w.b[23:0], 3'd0};
            sm27  = {w.q[23:0], 3'd0};
            if (w.r[7:0] >= 8'd27) begin
              smx = 27'd1;
            end else begin
              lmask = (27'd1 << w.r[4:0]) - 27'd1;
              smx = (sm27 >> w.r[4:0]) | {26'd0, |(sm27 & lmask)};
            end
            if (w.r[8]) sum = {1'b0, big27} - {1'b0, smx};
            else        sum = {1'b0, big27} + {1'b0, smx};
            w.a = {26'd0, sum};
          end else if (k == 1) begin
            if (w.a[27:0] == 28'd0) begin
              w.spec = 1'b1;
              w.sval = 32'd0;
            end else begin
              for (int i = 0; i < 28; i++) begin
                if (w.a[i]) lz = 5'(27 - i);
              end
              sh28 = w.a[27:0] << lz;
              w.q  = sh28[27:1];
              w.st = sh28[0];
              w.e  = w.e + 12'sd1 - $signed({7'd0, lz});
            end
          end
        end
        OP_DIV: begin
          ge  = w.a[25:0] >= {2'd0, w.b[23:0]};
          rem = ge ? (w.a[25:0] - {2'd0, w.b[23:0]}) : w.a[25:0];
          w.q = {w.q[25:0], ge};
          w.a = {28'd0, rem[24:0], 1'b0};
          if (k == ERF_ITER - 1) w.st = rem != 26'd0;
        end
        OP_SQRT: begin
          rem2  = {w.r, w.a[53:52]};
          trial = {2'd0, w.q, 2'b01};
          ge    = rem2 >= trial;
          w.r   = ge ? 29'(rem2 - trial) : rem2[28:0];
          w.q   = {w.q[25:0], ge};
          w.a   = {w.a[51:0], 2'd0};
          if (k == ERF_ITER - 1) w.st = w.r != 29'd0;
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Round to nearest even and pack, with gradual underflow and overflow to infinity.
  function automatic logic [31:0] finish(input erf_wk_t w);
    logic [31:0] res;
    logic [26:0] qs, lmask;
    logic [7:0]  expf;
    logic [11:0] shv;
    logic        lost, up;
    logic [30:0] pk;
    lost = 1'b0;
    qs   = w.q;
    expf = 8'd0;
    shv  = 12'd0;
    if (w.spec) begin
      res = w.sval;
    end else if (w.e > 12'sd127) begin
      res = {w.s, 31'h7F800000};
    end else begin
      if (w.e < -12'sd126) begin
        shv = 12'(-12'sd126 - w.e);
        if (shv >= 12'd27) begin
          qs   = 27'd0;
          lost = w.q != 27'd0;
        end else begin
          lmask = (27'd1 << shv[4:0]) - 27'd1;
          qs    = w.q >> shv[4:0];
          lost  = |(w.q & lmask);
        end
      end else begin
        expf = 8'(w.e + 12'sd127);
      end
      up  = qs[2] & (qs[1] | qs[0] | w.st | lost | qs[3]);
      pk  = {expf, qs[25:3]} + {30'd0, up};
      res = {w.s, pk};
    end
    return res;
  endfunction

  erf_wk_t stg [ERF_ITER+1];

  // Capture, iterate one stage per cycle while enabled, then round into the result register.
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= unpack(op, a, b);
      for (int k = 0; k < ERF_ITER; k++) begin
        stg[k+1] <= step(stg[k], k);
      end
      y <= finish(stg[ERF_ITER]);
    end
  end

endmodule

@@ dv/euler_rusanov_face_flux_core_tb.sv @@
// Stream testbench for the Rusanov face flux core with a bit-exact flux predictor.
module euler_rusanov_face_flux_core_tb;
  import erf_pkg::*;

  // Single-precision constants used by the flux arithmetic.
  localparam logic [31:0] K_0P4 = 32'h3ECCCCCD;
  localparam logic [31:0] K_0P2 = 32'h3E4CCCCD;
  localparam logic [31:0] K_1P4 = 32'h3FB33333;
  localparam logic [31:0] K_0P5 = 32'h3F000000;
  localparam logic [31:0] F_INF = 32'h7F800000;
  localparam int N_RANDOM = 1430;
  localparam int PIPE_DRAIN = 450;

  typedef struct {
    logic            direction;
    logic            at_face;
    logic            neighbor_open;
    logic [31:0]     normal_component;
    logic [3:0][31:0] own;
    logic [3:0][31:0] nbr;
  } point_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  point_t       point_queue[$];
  point_t       cur_point;
  logic [127:0] flux_queue[$];
  int           points_sent = 0;
  int           fluxes_seen = 0;
  int           mismatches = 0;
  logic         rx_hold = 1'b0;

  euler_rusanov_face_flux_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // Single-precision bits to an exact double.
  function automatic real sp_to_real(logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
    end
    if (b[30:23] == 8'h00) begin
      r = real'(b[22:0]) / (2.0 ** 149);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'b0});
  endfunction

  // Double to single precision, round to nearest even, with subnormals.
  function automatic logic [31:0] real_to_sp(real x);
    logic [63:0] d;
    logic [63:0] m, kept, rest, half;
    int e, sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? ERF_QNAN : {d[63], 31'h7F800000};
    end
    if (d[62:0] == 0) return {d[63], 31'b0};
    e = int'(d[62:52]) - 1023;
    m = {11'b0, 1'b1, d[51:0]};
    if (d[62:52] == 0) return {d[63], 31'b0};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh >= 60) return {d[63], 31'b0};
    kept = m >> sh;
    rest = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && kept[0])) kept++;
    if (e >= -126) begin
      if (kept == (64'd1 << 24)) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {d[63], 31'h7F800000};
      return {d[63], 8'(e + 127), kept[22:0]};
    end
    // A subnormal that rounds up to the smallest normal lands in the exponent field.
    return {d[63], kept[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
    return sp_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic is_nan(logic [31:0] a);
    return a[30:0] > 31'h7F800000;
  endfunction

  // Division by zero follows IEEE: 0/0 and NaN/0 are NaN, otherwise signed infinity.
  function automatic logic [31:0] sp_div(logic [31:0] a, logic [31:0] b);
    if (b[30:0] == 0) begin
      if (a[30:0] == 0 || is_nan(a)) return ERF_QNAN;
      return {a[31] ^ b[31], 31'h7F800000};
    end
    return real_to_sp(sp_to_real(a) / sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_sqrt(logic [31:0] a);
    if (a[30:0] == 0) return a;
    if (is_nan(a) || a[31]) return ERF_QNAN;
    if (a == F_INF) return a;
    return real_to_sp($sqrt(sp_to_real(a)));
  endfunction

  function automatic logic [31:0] pressure_of(logic [3:0][31:0] u);
    logic [31:0] t0, t1, t2;
    t0 = sp_mul(K_0P4, u[3]);
    t1 = sp_div(sp_mul(sp_mul(K_0P2, u[1]), u[1]), u[0]);
    t2 = sp_div(sp_mul(sp_mul(K_0P2, u[2]), u[2]), u[0]);
    return sp_sub(sp_sub(t0, t1), t2);
  endfunction

  function automatic logic [3:0][31:0] euler_flux(logic [3:0][31:0] u, logic [31:0] p,
                                                  logic direction);
    logic [3:0][31:0] f;
    logic [31:0] vn;
    vn = direction ? u[2] : u[1];
    f[0] = vn;
    f[1] = direction ? sp_div(sp_mul(u[1], u[2]), u[0])
                     : sp_add(sp_div(sp_mul(u[1], u[1]), u[0]), p);
    f[2] = direction ? sp_add(sp_div(sp_mul(u[2], u[2]), u[0]), p)
                     : sp_div(sp_mul(u[1], u[2]), u[0]);
    f[3] = sp_mul(sp_div(vn, u[0]), sp_add(u[3], p));
    return f;
  endfunction

  function automatic logic [31:0] wave_speed_of(logic [3:0][31:0] u, logic [31:0] p);
    logic [31:0] num, vel, snd;
    num = sp_add(sp_mul(u[1], u[1]), sp_mul(u[2], u[2]));
    vel = sp_sqrt(sp_div(num, sp_mul(u[0], u[0])));
    snd = sp_sqrt(sp_div(sp_mul(K_1P4, p), u[0]));
    return sp_add(vel, snd);
  endfunction

  // Expected m_tdata for one point: physical flux, or Rusanov flux at an open face.
  function automatic logic [127:0] face_flux(point_t pt);
    logic [3:0][31:0] f, fn;
    logic [31:0] p, pn, a, an, s, mean, jump;
    logic [127:0] packed_flux;
    p = pressure_of(pt.own);
    f = euler_flux(pt.own, p, pt.direction);
    if (pt.at_face && pt.neighbor_open) begin
      pn = pressure_of(pt.nbr);
      fn = euler_flux(pt.nbr, pn, pt.direction);
      a = wave_speed_of(pt.own, p);
      an = wave_speed_of(pt.nbr, pn);
      // A NaN on either side keeps the own speed.
      if (!is_nan(a) && !is_nan(an) && sp_to_real(a) < sp_to_real(an)) a = an;
      s = sp_mul(sp_mul(K_0P5, a), pt.normal_component);
      for (int k = 0; k < 4; k++) begin
        mean = sp_mul(K_0P5, sp_add(f[k], fn[k]));
        jump = sp_mul(s, sp_sub(pt.own[k], pt.nbr[k]));
        f[k] = sp_sub(mean, jump);
      end
    end
    for (int k = 0; k < 4; k++) begin
      packed_flux[32*k +: 32] = is_nan(f[k]) ? ERF_QNAN : f[k];
    end
    return packed_flux;
  endfunction

  function automatic logic [31:0] rand_real_sp(real lo, real hi);
    return real_to_sp(lo + (hi - lo) * real'($urandom_range(0, 1000000)) / 1000000.0);
  endfunction

  // A physically sensible state: positive density and pressure.
  function automatic logic [3:0][31:0] sane_state();
    logic [3:0][31:0] u;
    real rho, mx, my, pr;
    rho = sp_to_real(rand_real_sp(0.05, 10.0));
    mx = sp_to_real(rand_real_sp(-20.0, 20.0));
    my = sp_to_real(rand_real_sp(-20.0, 20.0));
    pr = sp_to_real(rand_real_sp(0.01, 50.0));
    u[0] = real_to_sp(rho);
    u[1] = real_to_sp(mx);
    u[2] = real_to_sp(my);
    u[3] = real_to_sp(pr / 0.4 + 0.5 * (mx * mx + my * my) / rho);
    return u;
  endfunction

  function automatic logic [3:0][31:0] raw_state();
    logic [3:0][31:0] u;
    for (int k = 0; k < 4; k++) u[k] = $urandom;
    return u;
  endfunction

  function automatic point_t make_point(logic [2:0] flags, logic [31:0] nrm,
                                        logic [3:0][31:0] own, logic [3:0][31:0] nbr);
    point_t pt;
    pt.direction = flags[0];
    pt.at_face = flags[1];
    pt.neighbor_open = flags[2];
    pt.normal_component = nrm;
    pt.own = own;
    pt.nbr = nbr;
    return pt;
  endfunction

  // Sender: offers points from the queue with random gaps per phase.
  always @(posedge clk) begin
    int gap_pct;
    gap_pct = (points_sent < 480) ? 35 : (points_sent < 960) ? 74 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        flux_queue.push_back(face_flux(cur_point));
        points_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (point_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          cur_point = point_queue.pop_front();
          s_tdata <= {cur_point.nbr[3], cur_point.nbr[2], cur_point.nbr[1], cur_point.nbr[0],
                      cur_point.own[3], cur_point.own[2], cur_point.own[1], cur_point.own[0],
                      cur_point.normal_component};
          s_tuser <= {cur_point.neighbor_open, cur_point.at_face, cur_point.direction};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls per phase, compares each flux item with the oldest prediction.
  always @(posedge clk) begin
    int stall_pct;
    logic [127:0] want;
    stall_pct = (fluxes_seen < 480) ? 74 : (fluxes_seen < 960) ? 35 : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        fluxes_seen++;
        if (flux_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected flux item %h", m_tdata);
        end else begin
          want = flux_queue.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("Flux item %0d field %0d: expected %h, got %h",
                         fluxes_seen - 1, k, want[32*k +: 32], m_tdata[32*k +: 32]);
            end
          end
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up the input.
  initial begin
    wait (fluxes_seen >= 100);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (900) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Run limit.
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [3:0][31:0] zero4, ones4, nz;
    zero4 = '0;
    ones4 = '1;
    // Directed points: every flag combination on sane states.
    for (int f = 0; f < 8; f++)
      point_queue.push_back(make_point(3'(f), rand_real_sp(-1.0, 1.0), sane_state(),
                                       sane_state()));
    // Field extremes: all zeros (zero density) and all ones (NaN).
    point_queue.push_back(make_point(3'b111, 32'h0, zero4, zero4));
    point_queue.push_back(make_point(3'b111, 32'hFFFFFFFF, ones4, ones4));
    point_queue.push_back(make_point(3'b110, 32'h3F800000, zero4, sane_state()));
    // Nonzero momentum over zero density gives infinities.
    nz = sane_state();
    nz[0] = 32'h80000000;
    point_queue.push_back(make_point(3'b111, 32'hBF800000, nz, sane_state()));
    point_queue.push_back(make_point(3'b000, 32'h0, nz, zero4));
    // Negative pressure makes the operand of the sound speed root negative.
    nz = sane_state();
    nz[3] = 32'hC1200000;
    point_queue.push_back(make_point(3'b111, 32'h3F800000, nz, sane_state()));
    point_queue.push_back(make_point(3'b110, 32'h3F800000, sane_state(), nz));
    // Infinite energy and infinite normal component.
    nz = sane_state();
    nz[3] = F_INF;
    point_queue.push_back(make_point(3'b111, F_INF, nz, sane_state()));
    // Subnormal density and largest finite values.
    nz = sane_state();
    nz[0] = 32'h00000001;
    point_queue.push_back(make_point(3'b111, 32'h007FFFFF, nz, sane_state()));
    point_queue.push_back(make_point(3'b110, 32'h7F7FFFFF,
                                     {4{32'h7F7FFFFF}}, {4{32'hFF7FFFFF}}));
    // Interior and closed-face points with garbage neighbor fields.
    point_queue.push_back(make_point(3'b000, 32'hFFFFFFFF, sane_state(), ones4));
    point_queue.push_back(make_point(3'b011, 32'hFFFFFFFF, sane_state(), ones4));
    point_queue.push_back(make_point(3'b101, 32'h7FC00000, sane_state(), ones4));
    // Random part: mostly sane states, some raw bit patterns.
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 80)
        point_queue.push_back(make_point(3'($urandom), rand_real_sp(-1.0, 1.0),
                                         sane_state(), sane_state()));
      else
        point_queue.push_back(make_point(3'($urandom), $urandom, raw_state(), raw_state()));
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (point_queue.size() == 0 && !s_tvalid && flux_queue.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (flux_queue.size() == 0 && mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
